// ----- sv/pbfp_pkg.sv -----
// ----------------------------------------------------------------------------
// pbfp_pkg
// shared types, constants and arithmetic helpers of the prefix best-face
// predictor: operation codes, item control flags, prediction update rules
// ----------------------------------------------------------------------------
package pbfp_pkg;

   localparam int OP_W    = 3;
   localparam int ENTRY_W = 10;
   localparam int PRED_W  = 18;
   localparam int MIN_W   = 18;
   localparam int RANGE_W = 17;
   localparam int SUFFIX_W = 8;

   localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
   localparam logic [OP_W-1:0] OP_INHERIT = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd2;
   localparam logic [OP_W-1:0] OP_SATISFY = 3'd3;
   localparam logic [OP_W-1:0] OP_ADJUST  = 3'd4;
   localparam logic [OP_W-1:0] OP_AGE     = 3'd5;

   localparam logic [PRED_W-1:0]  PRED_INIT    = 18'd8192;
   localparam logic [PRED_W-1:0]  PRED_FLOOR   = 18'd127;
   localparam logic [PRED_W-1:0]  PRED_CAP     = 18'd160000;
   localparam logic [MIN_W-1:0]   NOBEST_MIN   = 18'd4000;
   localparam logic [RANGE_W-1:0] NOBEST_RANGE = 17'd75000;

   typedef struct packed {
      logic do_init;
      logic do_inherit;
      logic do_query;
      logic do_satisfy;
      logic do_grow;
      logic grow_parent;
      logic do_age;
   } item_ctrl_type;

   localparam int CTRL_W = $bits(item_ctrl_type);

   // grow by one eighth, capped
   function automatic logic [PRED_W-1:0] grow_pred(input logic [PRED_W-1:0] t);
      logic [PRED_W:0] n;
      n = {1'b0, t} + {4'd0, t[PRED_W-1:3]};
      if (n > {1'b0, PRED_CAP}) begin
         return PRED_CAP;
      end
      return n[PRED_W-1:0];
   endfunction

   // shrink by one 128th, floored
   function automatic logic [PRED_W-1:0] shrink_pred(input logic [PRED_W-1:0] t);
      logic [PRED_W-1:0] n;
      n = t - {7'd0, t[PRED_W-1:7]};
      if (n < PRED_FLOOR) begin
         return PRED_FLOOR;
      end
      return n;
   endfunction

   // half of the prediction, rounded up
   function automatic logic [RANGE_W-1:0] half_up(input logic [PRED_W-1:0] t);
      logic [PRED_W:0] s;
      s = {1'b0, t} + {{PRED_W{1'b0}}, 1'b1};
      return s[RANGE_W:1];
   endfunction

endpackage

// ----- sv/pbfp_ram.sv -----
// ----------------------------------------------------------------------------
// pbfp_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pbfp_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pbfp_front.sv -----
// ----------------------------------------------------------------------------
// pbfp_front
// decodes an incoming transaction into operation flags and reduces the
// entry and parent indexes to table slots
// ----------------------------------------------------------------------------
module pbfp_front #(
   parameter int NUM_ENTRIES = 1024,
   parameter int FACE_BITS   = 16
) (
   input  logic [pbfp_pkg::OP_W-1:0]            req_operation,
   input  logic [pbfp_pkg::ENTRY_W-1:0]         req_entry,
   input  logic [pbfp_pkg::ENTRY_W-1:0]         req_parent_entry,
   input  logic                                 req_has_parent,
   input  logic [FACE_BITS-1:0]                 req_face_id,
   input  logic signed [pbfp_pkg::SUFFIX_W-1:0] req_matching_suffix,
   output pbfp_pkg::item_ctrl_type              item_ctrl,
   output logic [$clog2(NUM_ENTRIES)-1:0]       item_entry,
   output logic [$clog2(NUM_ENTRIES)-1:0]       item_parent,
   output logic [FACE_BITS-1:0]                 item_face
);
   import pbfp_pkg::*;

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int RW    = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

   // index modulo table depth by restoring subtraction
   function automatic logic [IDX_W-1:0] slot_of(input logic [ENTRY_W-1:0] raw);
      logic [RW-1:0] v;
      v = RW'(raw);
      for (int k = ENTRY_W - 1; k >= 0; k--) begin
         if ((NUM_ENTRIES << k) < (1 << ENTRY_W)) begin
            if (v >= RW'(NUM_ENTRIES << k)) begin
               v = v - RW'(NUM_ENTRIES << k);
            end
         end
      end
      return v[IDX_W-1:0];
   endfunction

   logic suffix_ok;

   assign suffix_ok = (req_matching_suffix == 8'sd0) || (req_matching_suffix == 8'sd1);

   always_comb begin
      item_ctrl = '0;
      unique case (req_operation)
         OP_INIT: begin
            item_ctrl.do_init = 1'b1;
         end
         OP_INHERIT: begin
            item_ctrl.do_inherit = 1'b1;
         end
         OP_QUERY: begin
            item_ctrl.do_query = 1'b1;
         end
         OP_SATISFY: begin
            item_ctrl.do_satisfy = suffix_ok;
         end
         OP_ADJUST: begin
            item_ctrl.do_grow     = 1'b1;
            item_ctrl.grow_parent = req_has_parent;
         end
         OP_AGE: begin
            item_ctrl.do_age = 1'b1;
         end
         default: begin
            item_ctrl = '0;
         end
      endcase
   end

   assign item_entry  = slot_of(req_entry);
   assign item_parent = slot_of(req_parent_entry);
   assign item_face   = req_face_id;

endmodule

// ----- sv/pbfp_queue.sv -----
// ----------------------------------------------------------------------------
// pbfp_queue
// two-deep queue of decoded transactions between front and back
// ----------------------------------------------------------------------------
module pbfp_queue #(
   parameter int WIDTH = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- sv/pbfp_back.sv -----
// ----------------------------------------------------------------------------
// pbfp_back
// read-modify-write sequencer on the entry table; updates the entry,
// optionally grows the parent, and loads the result register
// ----------------------------------------------------------------------------
module pbfp_back #(
   parameter int NUM_ENTRIES = 1024,
   parameter int FACE_BITS   = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          item_valid,
   output logic                                          item_pop,
   input  pbfp_pkg::item_ctrl_type                       item_ctrl,
   input  logic [$clog2(NUM_ENTRIES)-1:0]                item_entry,
   input  logic [$clog2(NUM_ENTRIES)-1:0]                item_parent,
   input  logic [FACE_BITS-1:0]                          item_face,
   output logic                                          ram_wr_en,
   output logic [$clog2(NUM_ENTRIES)-1:0]                ram_wr_addr,
   output logic [2*FACE_BITS+pbfp_pkg::PRED_W-1:0]       ram_wr_data,
   output logic                                          ram_rd_en,
   output logic [$clog2(NUM_ENTRIES)-1:0]                ram_rd_addr,
   input  logic [2*FACE_BITS+pbfp_pkg::PRED_W-1:0]       ram_rd_data,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [FACE_BITS-1:0]                          rsp_best_face,
   output logic                                          rsp_no_best,
   output logic [pbfp_pkg::MIN_W-1:0]                    rsp_delay_low,
   output logic [pbfp_pkg::RANGE_W-1:0]                  rsp_delay_span
);
   import pbfp_pkg::*;

   localparam int IDX_W  = $clog2(NUM_ENTRIES);
   localparam int WORD_W = 2 * FACE_BITS + PRED_W;
   localparam logic [FACE_BITS-1:0] FACE_NONE = '1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_PREAD  = 4'b0100,
      ST_PWRITE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   item_ctrl_type     ctrl_ff, ctrl_in;
   logic [IDX_W-1:0]  entry_ff, entry_in;
   logic [IDX_W-1:0]  parent_ff, parent_in;
   logic [FACE_BITS-1:0] face_ff, face_in;
   logic [WORD_W-1:0] saved_ff, saved_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FACE_BITS-1:0] rsp_best_ff, rsp_best_in;
   logic              rsp_no_best_ff, rsp_no_best_in;
   logic [MIN_W-1:0]  rsp_min_ff, rsp_min_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;

   logic [FACE_BITS-1:0] rd_best, rd_prev, nb, np;
   logic [PRED_W-1:0]    rd_pred, nt;
   logic [WORD_W-1:0]    upd_word, par_word, rep_word;
   logic [FACE_BITS-1:0] rep_best;
   logic [PRED_W-1:0]    rep_pred;
   logic                 rep_none;
   logic                 start;
   logic                 load;

   assign rd_best = ram_rd_data[WORD_W-1 -: FACE_BITS];
   assign rd_prev = ram_rd_data[PRED_W+FACE_BITS-1 -: FACE_BITS];
   assign rd_pred = ram_rd_data[PRED_W-1:0];

   // entry update
   always_comb begin
      nb = rd_best;
      np = rd_prev;
      nt = rd_pred;
      if (ctrl_ff.do_init) begin
         nb = FACE_NONE;
         np = FACE_NONE;
         nt = PRED_INIT;
      end
      if (ctrl_ff.do_query && (rd_best == FACE_NONE)) begin
         nb = rd_prev;
      end
      if (ctrl_ff.do_satisfy) begin
         if (face_ff == FACE_NONE) begin
            nb = FACE_NONE;
            np = FACE_NONE;
         end else if (face_ff == rd_best) begin
            nt = shrink_pred(rd_pred);
         end else if (rd_best == FACE_NONE) begin
            nb = face_ff;
         end else begin
            np = rd_best;
            nb = face_ff;
         end
      end
      if (ctrl_ff.do_grow) begin
         nt = grow_pred(rd_pred);
      end
      if (ctrl_ff.do_age) begin
         np = rd_best;
         nb = FACE_NONE;
      end
   end

   assign upd_word = {nb, np, nt};
   assign par_word = {rd_best, rd_prev, grow_pred(rd_pred)};
   assign rep_word = (state_ff == ST_PWRITE) ?
                     ((parent_ff == entry_ff) ? par_word : saved_ff) : upd_word;
   assign rep_best = rep_word[WORD_W-1 -: FACE_BITS];
   assign rep_pred = rep_word[PRED_W-1:0];
   assign rep_none = (rep_best == FACE_NONE);

   assign start    = (state_ff == ST_IDLE) && item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop = start;

   always_comb begin
      state_in    = state_ff;
      ctrl_in     = ctrl_ff;
      entry_in    = entry_ff;
      parent_in   = parent_ff;
      face_in     = face_ff;
      saved_in    = saved_ff;
      load        = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = entry_ff;
      ram_wr_data = upd_word;
      ram_rd_en   = 1'b0;
      ram_rd_addr = item_ctrl.do_inherit ? item_parent : item_entry;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl_in   = item_ctrl;
               entry_in  = item_entry;
               parent_in = item_parent;
               face_in   = item_face;
               ram_rd_en = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            ram_wr_en = 1'b1;
            if (ctrl_ff.grow_parent) begin
               saved_in = upd_word;
               state_in = ST_PREAD;
            end else begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PREAD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = parent_ff;
            state_in    = ST_PWRITE;
         end
         ST_PWRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = parent_ff;
            ram_wr_data = par_word;
            load        = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_best_in    = rsp_best_ff;
      rsp_no_best_in = rsp_no_best_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_range_in   = rsp_range_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_best_in    = rep_best;
         rsp_no_best_in = rep_none;
         rsp_min_in     = rep_none ? NOBEST_MIN : rep_pred;
         rsp_range_in   = rep_none ? NOBEST_RANGE : half_up(rep_pred);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff        <= ctrl_in;
      entry_ff       <= entry_in;
      parent_ff      <= parent_in;
      face_ff        <= face_in;
      saved_ff       <= saved_in;
      rsp_best_ff    <= rsp_best_in;
      rsp_no_best_ff <= rsp_no_best_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_range_ff   <= rsp_range_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_face  = rsp_best_ff;
   assign rsp_no_best    = rsp_no_best_ff;
   assign rsp_delay_low  = rsp_min_ff;
   assign rsp_delay_span = rsp_range_ff;

endmodule

// ----- sv/prefix_best_face_predictor.sv -----
// ----------------------------------------------------------------------------
// prefix_best_face_predictor
// table of name-prefix entries holding best face, previous face and a
// response-time prediction; one operation per transaction, one result each
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_ready  operation, entry, parent, face, suffix
//   rsp_      out         rsp_valid / rsp_ready  best face, no-best flag, deferral window
//
// each transaction is a table read, then a write; adjust-up with a parent adds a
// parent read and write, set by the single read and single write port of the table.
// reset clears the queue and sequencer only; table contents stay undefined
// until written. a two-deep queue takes up to two transactions while a result waits.
// ----------------------------------------------------------------------------
module prefix_best_face_predictor #(
   parameter int NUM_ENTRIES = 1024,
   parameter int FACE_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pbfp_pkg::OP_W-1:0]            req_operation,
   input  logic [pbfp_pkg::ENTRY_W-1:0]         req_entry,
   input  logic [pbfp_pkg::ENTRY_W-1:0]         req_parent_entry,
   input  logic                                 req_has_parent,
   input  logic [FACE_BITS-1:0]                 req_face_id,
   input  logic signed [pbfp_pkg::SUFFIX_W-1:0] req_matching_suffix,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [FACE_BITS-1:0]                 rsp_best_face,
   output logic                                 rsp_no_best,
   output logic [pbfp_pkg::MIN_W-1:0]           rsp_delay_low,
   output logic [pbfp_pkg::RANGE_W-1:0]         rsp_delay_span
);
   import pbfp_pkg::*;

   localparam int IDX_W  = $clog2(NUM_ENTRIES);
   localparam int WORD_W = 2 * FACE_BITS + PRED_W;
   localparam int Q_W    = CTRL_W + 2 * IDX_W + FACE_BITS;

   item_ctrl_type        f_ctrl, b_ctrl;
   logic [IDX_W-1:0]     f_entry, f_parent, b_entry, b_parent;
   logic [FACE_BITS-1:0] f_face, b_face;
   logic [Q_W-1:0]       q_in_data, q_out_data;
   logic                 q_out_valid;
   logic                 q_pop;
   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]    ram_wr_data, ram_rd_data;

   pbfp_front #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .FACE_BITS   (FACE_BITS)
   ) u_front (
      .req_operation       (req_operation),
      .req_entry           (req_entry),
      .req_parent_entry    (req_parent_entry),
      .req_has_parent      (req_has_parent),
      .req_face_id         (req_face_id),
      .req_matching_suffix (req_matching_suffix),
      .item_ctrl           (f_ctrl),
      .item_entry          (f_entry),
      .item_parent         (f_parent),
      .item_face           (f_face)
   );

   assign q_in_data = {f_ctrl, f_entry, f_parent, f_face};

   pbfp_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_pop   (q_pop),
      .out_data  (q_out_data)
   );

   assign {b_ctrl, b_entry, b_parent, b_face} = q_out_data;

   pbfp_back #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .FACE_BITS   (FACE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (q_out_valid),
      .item_pop       (q_pop),
      .item_ctrl      (b_ctrl),
      .item_entry     (b_entry),
      .item_parent    (b_parent),
      .item_face      (b_face),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_face  (rsp_best_face),
      .rsp_no_best    (rsp_no_best),
      .rsp_delay_low  (rsp_delay_low),
      .rsp_delay_span (rsp_delay_span)
   );

   pbfp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
